FILE: rtl/core/cia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types, codes and helpers of the checked 64-bit integer ALU.
// ----------------------------------------------------------------------------
package cia_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam int ACC_W      = DATA_WIDTH + 2;
    localparam int SHL_LIMIT  = 127;

    typedef enum logic [4:0] {
        OP_ADD      = 5'd0,
        OP_SUB      = 5'd1,
        OP_MUL      = 5'd2,
        OP_FLOORDIV = 5'd3,
        OP_REM      = 5'd4,
        OP_MIN      = 5'd5,
        OP_MAX      = 5'd6,
        OP_AND      = 5'd7,
        OP_OR       = 5'd8,
        OP_XOR      = 5'd9,
        OP_SHL      = 5'd10,
        OP_SHR      = 5'd11,
        OP_POW      = 5'd12,
        OP_EQ       = 5'd13,
        OP_NE       = 5'd14,
        OP_LT       = 5'd15,
        OP_LE       = 5'd16,
        OP_GT       = 5'd17,
        OP_GE       = 5'd18,
        OP_NEG      = 5'd19
    } op_t;

    typedef enum logic [2:0] {
        ERR_OK   = 3'd0,
        ERR_OVF  = 3'd1,
        ERR_DIV0 = 3'd2,
        ERR_NEG  = 3'd3,
        ERR_BIG  = 3'd4
    } err_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_MUL_FIN,
        ST_DIV,
        ST_DIV_FIN,
        ST_POW_CHK,
        ST_POW_SHIFT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MK_PLAIN,
        MK_ACC,
        MK_BASE
    } mul_kind_t;

    typedef enum logic {
        STEP_ADD,
        STEP_SUB
    } step_op_t;

    typedef struct packed {
        logic [4:0]                   req_type;
        logic signed [DATA_WIDTH-1:0] operand_a;
        logic signed [DATA_WIDTH-1:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result_value;
        logic [2:0]                   error_code;
    } rsp_t;

    typedef struct packed {
        logic done;
        rsp_t rsp;
    } core_status_t;

    function automatic logic [DATA_WIDTH-1:0] mag(input logic [DATA_WIDTH-1:0] v);
        return v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/cia_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_step
// Shared add/subtract unit used by every multiply and divide iteration.
// ----------------------------------------------------------------------------
module cia_step (
    input  cia_pkg::step_op_t         op,
    input  logic [cia_pkg::ACC_W-1:0] x,
    input  logic [cia_pkg::ACC_W-1:0] y,
    output logic [cia_pkg::ACC_W-1:0] sum
);
    import cia_pkg::*;

    logic [ACC_W-1:0] y_eff;
    logic             carry_in;

    always_comb
    begin
        unique case (op)
            STEP_SUB:
            begin
                y_eff    = ~y;
                carry_in = 1'b1;
            end
            default:
            begin
                y_eff    = y;
                carry_in = 1'b0;
            end
        endcase
    end

    assign sum = x + y_eff + {{(ACC_W-1){1'b0}}, carry_in};

endmodule
`default_nettype wire

FILE: rtl/core/cia_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_core
// Sequencer of the ALU: simple ops, shift-add multiply, restoring
// divide and square-and-multiply power, these three on one shared step unit.
// ----------------------------------------------------------------------------
module cia_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  busy,
    input  cia_pkg::req_t         req,
    input  logic                  rsp_ack,
    output cia_pkg::core_status_t status
);
    import cia_pkg::*;

    localparam logic [ACC_W-1:0]      MUL_LIMIT = {{(ACC_W-DATA_WIDTH){1'b0}}, 1'b1,
                                                   {(DATA_WIDTH-1){1'b0}}};
    localparam logic [CNT_W-1:0]      CNT_LAST  = CNT_W'(DATA_WIDTH - 1);
    localparam logic [DATA_WIDTH-1:0] ALL_ONES  = {DATA_WIDTH{1'b1}};
    localparam logic [DATA_WIDTH-1:0] MIN_VAL   = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] ONE_VAL   = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [DATA_WIDTH-1:0] a_reg, a_next;
    logic [DATA_WIDTH-1:0] b_reg, b_next;
    logic [DATA_WIDTH-1:0] res_reg, res_next;
    err_t                  err_reg, err_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [ACC_W-1:0]      macc_reg, macc_next;
    logic [DATA_WIDTH-1:0] mua_reg, mua_next;
    logic [DATA_WIDTH-1:0] mub_reg, mub_next;
    logic                  mneg_reg, mneg_next;
    logic                  msticky_reg, msticky_next;
    mul_kind_t             mkind_reg, mkind_next;
    logic [DATA_WIDTH-1:0] pacc_reg, pacc_next;
    logic [DATA_WIDTH-1:0] pbase_reg, pbase_next;
    logic [DATA_WIDTH-1:0] prem_reg, prem_next;
    logic [DATA_WIDTH-1:0] dp_reg, dp_next;
    logic [DATA_WIDTH-1:0] dq_reg, dq_next;

    // shared step unit
    step_op_t         step_op;
    logic [ACC_W-1:0] step_x;
    logic [ACC_W-1:0] step_y;
    logic [ACC_W-1:0] step_sum;

    cia_step u_step (
        .op  (step_op),
        .x   (step_x),
        .y   (step_y),
        .sum (step_sum)
    );

    // simple operation logic on the incoming request
    logic [DATA_WIDTH-1:0] in_a, in_b;
    logic [DATA_WIDTH-1:0] add_s, sub_s;
    logic                  add_ovf, sub_ovf;
    logic                  a_lt_b, b_lt_a, a_eq_b;
    logic [CNT_W:0]        shl_amt;
    logic [DATA_WIDTH-1:0] shl_mask, shl_s, shr_s;
    logic                  shl_ovf, b_ge_64, b_ge_127, b_ge_63;

    assign in_a     = req.operand_a;
    assign in_b     = req.operand_b;
    assign add_s    = in_a + in_b;
    assign sub_s    = in_a - in_b;
    assign add_ovf  = ((in_a ^ add_s) & (in_b ^ add_s)) >> (DATA_WIDTH - 1) != '0;
    assign sub_ovf  = ((in_a ^ in_b) & (in_a ^ sub_s)) >> (DATA_WIDTH - 1) != '0;
    assign a_lt_b   = $signed(in_a) < $signed(in_b);
    assign b_lt_a   = $signed(in_b) < $signed(in_a);
    assign a_eq_b   = in_a == in_b;
    assign b_ge_127 = in_b >= DATA_WIDTH'(SHL_LIMIT);
    assign b_ge_64  = in_b >= DATA_WIDTH'(DATA_WIDTH);
    assign b_ge_63  = in_b >= DATA_WIDTH'(DATA_WIDTH - 1);
    // top count+1 bits of a must all equal its sign
    assign shl_amt  = {1'b0, in_b[CNT_W-1:0]} + 1'b1;
    assign shl_mask = ~(ALL_ONES >> shl_amt);
    assign shl_ovf  = |((in_a ^ {DATA_WIDTH{in_a[DATA_WIDTH-1]}}) & shl_mask);
    assign shl_s    = in_a << in_b[CNT_W-1:0];
    assign shr_s    = DATA_WIDTH'($signed(in_a) >>> in_b[CNT_W-1:0]);

    // multiply finish values
    logic                  mul_ovf;
    logic [DATA_WIDTH-1:0] mul_prod;
    assign mul_ovf  = msticky_reg || (!mneg_reg && macc_reg == MUL_LIMIT);
    assign mul_prod = mneg_reg ? (~macc_reg[DATA_WIDTH-1:0] + 1'b1)
                               : macc_reg[DATA_WIDTH-1:0];

    // divide step
    logic [DATA_WIDTH:0] div_p2;
    assign div_p2 = {dp_reg, dq_reg[DATA_WIDTH-1]};

    logic                  mul_start;
    logic [DATA_WIDTH-1:0] mul_x, mul_y;
    mul_kind_t             mul_kind;
    logic                  mul_bit;
    logic                  div_diff;
    logic [DATA_WIDTH-1:0] prem_shift;

    assign mul_bit    = mub_reg[cnt_reg];
    assign div_diff   = a_reg[DATA_WIDTH-1] ^ b_reg[DATA_WIDTH-1];
    assign prem_shift = prem_reg >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        res_reg     <= res_next;
        err_reg     <= err_next;
        cnt_reg     <= cnt_next;
        macc_reg    <= macc_next;
        mua_reg     <= mua_next;
        mub_reg     <= mub_next;
        mneg_reg    <= mneg_next;
        msticky_reg <= msticky_next;
        mkind_reg   <= mkind_next;
        pacc_reg    <= pacc_next;
        pbase_reg   <= pbase_next;
        prem_reg    <= prem_next;
        dp_reg      <= dp_next;
        dq_reg      <= dq_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        res_next     = res_reg;
        err_next     = err_reg;
        cnt_next     = cnt_reg;
        macc_next    = macc_reg;
        mua_next     = mua_reg;
        mub_next     = mub_reg;
        mneg_next    = mneg_reg;
        msticky_next = msticky_reg;
        mkind_next   = mkind_reg;
        pacc_next    = pacc_reg;
        pbase_next   = pbase_reg;
        prem_next    = prem_reg;
        dp_next      = dp_reg;
        dq_next      = dq_reg;
        step_op      = STEP_ADD;
        step_x       = '0;
        step_y       = '0;
        mul_start    = 1'b0;
        mul_x        = '0;
        mul_y        = '0;
        mul_kind     = MK_PLAIN;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = op_t'(req.req_type);
                    a_next     = in_a;
                    b_next     = in_b;
                    res_next   = '0;
                    err_next   = ERR_OK;
                    state_next = ST_DONE;
                    unique case (op_t'(req.req_type))
                        OP_ADD:
                        begin
                            if (add_ovf) err_next = ERR_OVF;
                            else res_next = add_s;
                        end
                        OP_SUB:
                        begin
                            if (sub_ovf) err_next = ERR_OVF;
                            else res_next = sub_s;
                        end
                        OP_MUL:
                        begin
                            mul_start = 1'b1;
                            mul_x     = in_a;
                            mul_y     = in_b;
                            mul_kind  = MK_PLAIN;
                        end
                        OP_FLOORDIV, OP_REM:
                        begin
                            if (in_b == '0)
                                err_next = ERR_DIV0;
                            else if (in_a == MIN_VAL && in_b == ALL_ONES)
                                err_next = ERR_OVF;
                            else
                            begin
                                dp_next    = '0;
                                dq_next    = mag(in_a);
                                mub_next   = mag(in_b);
                                cnt_next   = CNT_LAST;
                                state_next = ST_DIV;
                            end
                        end
                        OP_MIN:  res_next = b_lt_a ? in_b : in_a;
                        OP_MAX:  res_next = a_lt_b ? in_b : in_a;
                        OP_AND:  res_next = in_a & in_b;
                        OP_OR:   res_next = in_a | in_b;
                        OP_XOR:  res_next = in_a ^ in_b;
                        OP_SHL:
                        begin
                            priority if (in_b[DATA_WIDTH-1]) err_next = ERR_NEG;
                            else if (b_ge_127)               err_next = ERR_BIG;
                            else if (in_a == '0)             res_next = '0;
                            else if (b_ge_64 || shl_ovf)     err_next = ERR_OVF;
                            else                             res_next = shl_s;
                        end
                        OP_SHR:
                        begin
                            priority if (in_b[DATA_WIDTH-1]) err_next = ERR_NEG;
                            else if (b_ge_63) res_next = {DATA_WIDTH{in_a[DATA_WIDTH-1]}};
                            else              res_next = shr_s;
                        end
                        OP_POW:
                        begin
                            if (in_b[DATA_WIDTH-1])
                                err_next = ERR_NEG;
                            else
                            begin
                                pacc_next  = ONE_VAL;
                                pbase_next = in_a;
                                prem_next  = in_b;
                                state_next = ST_POW_CHK;
                            end
                        end
                        OP_EQ:   res_next = DATA_WIDTH'(a_eq_b);
                        OP_NE:   res_next = DATA_WIDTH'(!a_eq_b);
                        OP_LT:   res_next = DATA_WIDTH'(a_lt_b);
                        OP_LE:   res_next = DATA_WIDTH'(!b_lt_a);
                        OP_GT:   res_next = DATA_WIDTH'(b_lt_a);
                        OP_GE:   res_next = DATA_WIDTH'(!a_lt_b);
                        OP_NEG:  res_next = (in_a == MIN_VAL) ? in_a : (~in_a + 1'b1);
                        default: res_next = '0;
                    endcase
                end
            end

            ST_MUL:
            begin
                // msb-first shift-add, sticky once magnitude passes 2^(w-1)
                step_op = STEP_ADD;
                step_x  = {macc_reg[ACC_W-2:0], 1'b0};
                step_y  = {2'b00, mul_bit ? mua_reg : {DATA_WIDTH{1'b0}}};
                if (!msticky_reg)
                begin
                    macc_next = step_sum;
                    if (step_sum > MUL_LIMIT) msticky_next = 1'b1;
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) state_next = ST_MUL_FIN;
            end

            ST_MUL_FIN:
            begin
                unique case (mkind_reg)
                    MK_ACC:
                    begin
                        if (mul_ovf)
                        begin
                            res_next   = '0;
                            err_next   = ERR_OVF;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            pacc_next  = mul_prod;
                            state_next = ST_POW_SHIFT;
                        end
                    end
                    MK_BASE:
                    begin
                        if (mul_ovf)
                        begin
                            res_next   = '0;
                            err_next   = ERR_OVF;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            pbase_next = mul_prod;
                            state_next = ST_POW_CHK;
                        end
                    end
                    default:
                    begin
                        res_next   = mul_ovf ? '0 : mul_prod;
                        err_next   = mul_ovf ? ERR_OVF : ERR_OK;
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_DIV:
            begin
                step_op = STEP_SUB;
                step_x  = {1'b0, div_p2};
                step_y  = {2'b00, mub_reg};
                if (!step_sum[ACC_W-1])
                begin
                    dp_next = step_sum[DATA_WIDTH-1:0];
                    dq_next = {dq_reg[DATA_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    dp_next = div_p2[DATA_WIDTH-1:0];
                    dq_next = {dq_reg[DATA_WIDTH-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) state_next = ST_DIV_FIN;
            end

            ST_DIV_FIN:
            begin
                err_next   = ERR_OK;
                state_next = ST_DONE;
                if (op_reg == OP_REM)
                    res_next = a_reg[DATA_WIDTH-1] ? (~dp_reg + 1'b1) : dp_reg;
                else if (!div_diff)
                    res_next = dq_reg;
                else if (dp_reg != '0)
                    res_next = ~dq_reg;
                else
                    res_next = ~dq_reg + 1'b1;
            end

            ST_POW_CHK:
            begin
                priority if (prem_reg == '0)
                begin
                    res_next   = pacc_reg;
                    err_next   = ERR_OK;
                    state_next = ST_DONE;
                end
                else if (prem_reg[0])
                begin
                    mul_start = 1'b1;
                    mul_x     = pacc_reg;
                    mul_y     = pbase_reg;
                    mul_kind  = MK_ACC;
                end
                else
                begin
                    state_next = ST_POW_SHIFT;
                end
            end

            ST_POW_SHIFT:
            begin
                prem_next = prem_shift;
                if (prem_shift != '0)
                begin
                    mul_start = 1'b1;
                    mul_x     = pbase_reg;
                    mul_y     = pbase_reg;
                    mul_kind  = MK_BASE;
                end
                else
                begin
                    res_next   = pacc_reg;
                    err_next   = ERR_OK;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (rsp_ack) state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (mul_start)
        begin
            mneg_next    = mul_x[DATA_WIDTH-1] ^ mul_y[DATA_WIDTH-1];
            mua_next     = mag(mul_x);
            mub_next     = mag(mul_y);
            macc_next    = '0;
            msticky_next = 1'b0;
            mkind_next   = mul_kind;
            cnt_next     = CNT_LAST;
            state_next   = ST_MUL;
        end
    end

    assign busy                     = state_reg != ST_IDLE;
    assign status.done              = state_reg == ST_DONE;
    assign status.rsp.result_value  = res_reg;
    assign status.rsp.error_code    = err_reg;

endmodule
`default_nettype wire

FILE: rtl/core/checked_int64_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// checked_int64_alu
// Signed 64-bit ALU with overflow, divide-by-zero and range checking.
// ----------------------------------------------------------------------------
// usage:
//   a request (req_type, operand_a, operand_b) enters on req/req_valid and is
//   taken when req_valid is high and req_stall is low. exactly one response
//   (result_value, error_code) leaves on rsp/rsp_valid and is taken when
//   rsp_stall is low. result_value is zero whenever error_code is not ok.
//   one request is worked at a time; req_stall stays high until its
//   response has moved into the output register.
//   add, sub, logic, compare, shifts and neg are worked out on the taken
//   request into the core result register, then loaded into the output
//   register. mul and floordiv/rem run 64 steps of the shared 66-bit
//   add/subtract unit, then a finishing state and the output load. pow
//   runs these multiplies, with up to two multiplies per exponent bit.
//   the output register lets the next request in while a response waits.
//   a stalled receiver holds the response steady; the block then waits
//   with its next result until the output register frees up.
//   reset clears the sequencer and the output valid; no memory to clear.
// ----------------------------------------------------------------------------
module checked_int64_alu (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  cia_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output cia_pkg::rsp_t  rsp
);
    import cia_pkg::*;

    core_status_t status;
    logic         busy;
    logic         rsp_ack;
    logic         rsp_valid_reg, rsp_valid_next;
    rsp_t         rsp_reg, rsp_next;

    cia_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .busy      (busy),
        .req       (req),
        .rsp_ack   (rsp_ack),
        .status    (status)
    );

    // output slot free when empty or being taken this cycle
    assign rsp_ack = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && !rsp_stall) rsp_valid_next = 1'b0;
        if (status.done && rsp_ack)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = status.rsp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign req_stall = busy;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

FILE: rtl/core/cia_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_checker
// Port-level checks of the checked ALU, bound to the top level.
// ----------------------------------------------------------------------------
module cia_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input cia_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input cia_pkg::rsp_t rsp
);
    import cia_pkg::*;

    // a held response keeps its valid and payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // any error forces a zero result
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.error_code != ERR_OK |-> rsp.result_value == '0)
        else $error("nonzero result with error");

    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.error_code == ERR_OK || rsp.error_code == ERR_OVF ||
                      rsp.error_code == ERR_DIV0 || rsp.error_code == ERR_NEG ||
                      rsp.error_code == ERR_BIG)
        else $error("undefined error code");

    // one request in flight: the input closes right after a request
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second request taken while busy");

    // a new response is only loaded while a request is in flight
    a_rsp_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("response appeared with no request in flight");

endmodule

bind checked_int64_alu cia_checker u_cia_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
`default_nettype wire
